### src/ramr_pkg.sv
// Package for the rational add/multiply/reduce block.
// Types and constants shared by the interfaces, the front and back parts and the top level.
package ramr_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_MUL = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [DATA_W-1:0] a_num;
        logic [DATA_W-1:0] a_den;
        logic [DATA_W-1:0] b_num;
        logic [DATA_W-1:0] b_den;
    } t_in_item;

    typedef struct packed {
        logic [DATA_W-1:0] res_num;
        logic [DATA_W-1:0] res_den;
        logic              error;
    } t_out_item;

    // Unreduced fraction passed from front to back.
    typedef struct packed {
        logic [DATA_W-1:0] num;
        logic [DATA_W-1:0] den;
    } t_frac;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GCD_START,
        ST_GCD_DIV,
        ST_RED_NUM,
        ST_RED_DEN,
        ST_DONE
    } t_back_state;

    typedef enum logic [2:0] {
        FS_IDLE,
        FS_MUL1,
        FS_MUL2,
        FS_SUM,
        FS_PUSH
    } t_front_state;

endpackage

### src/ramr_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on ramr_pkg.
interface ramr_in_if
    import ramr_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ramr_out_if
    import ramr_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### src/rational_add_mul_reduce_top.sv
// Channel  | Dir | Beat contents
// s_in     | in  | operation, a_num, a_den, b_num, b_den
// m_out    | out | res_num, res_den, error
// Front: one shared 32x32 multiplier, used in turn for the products; it takes no new item
// until the previous fraction is pushed. Back: each GCD remainder step is one bit-serial
// divide, followed by two reduction divides. The back part sets the rate.
// Reset is synchronous, active low, and clears control state only. Either side may stall;
// the two-entry queue lets the front accept the next item while the back is busy.
module rational_add_mul_reduce_top
    import ramr_pkg::*;
#(
    parameter int unsigned P_QUEUE_DEPTH = QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ramr_in_if.sink    s_in,
    ramr_out_if.source m_out
);
    logic  w_fv, w_fr, w_bv, w_br;
    t_frac w_ff, w_bf;

    ramr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_in.valid),
        .o_ready (s_in.ready),
        .i_item  (s_in.data),
        .o_valid (w_fv),
        .i_ready (w_fr),
        .o_frac  (w_ff)
    );

    ramr_queue #(.DEPTH(P_QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fv),
        .o_ready (w_fr),
        .i_data  (w_ff),
        .o_valid (w_bv),
        .i_ready (w_br),
        .o_data  (w_bf)
    );

    ramr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_bv),
        .o_ready (w_br),
        .i_frac  (w_bf),
        .o_valid (m_out.valid),
        .i_ready (m_out.ready),
        .o_item  (m_out.data)
    );
endmodule

### src/ramr_front.sv
// Front part: takes an input beat, replaces zero-denominator operands by 0/1, forms the
// wrapped numerator and denominator products. Depends on ramr_pkg.
module ramr_front
    import ramr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_in_item i_item,
    output logic     o_valid,
    input  logic     i_ready,
    output t_frac    o_frac
);
    t_front_state r_state, n_state;
    t_in_item     r_item, n_item;
    logic [DATA_W-1:0] r_p0, n_p0, r_p1, n_p1, r_den, n_den;
    logic [DATA_W-1:0] w_ma, w_mb;
    logic [2*DATA_W-1:0] w_prod;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FS_IDLE: if (i_valid) n_state = FS_MUL1;
            FS_MUL1: n_state = FS_MUL2;
            FS_MUL2: n_state = FS_SUM;
            FS_SUM:  n_state = FS_PUSH;
            FS_PUSH: if (i_ready) n_state = FS_IDLE;
            default: n_state = FS_IDLE;
        endcase
    end

    // one shared multiplier, three uses
    always_comb begin
        w_ma = r_item.a_den;
        w_mb = r_item.b_den;
        unique case (r_state)
            FS_MUL1: begin
                w_ma = r_item.a_num;
                w_mb = (r_item.operation == OP_MUL) ? r_item.b_num : r_item.b_den;
            end
            FS_MUL2: begin
                w_ma = r_item.b_num;
                w_mb = r_item.a_den;
            end
            default: begin
                w_ma = r_item.a_den;
                w_mb = r_item.b_den;
            end
        endcase
        w_prod = w_ma * w_mb;
    end

    always_comb begin
        n_item = r_item;
        n_p0   = r_p0;
        n_p1   = r_p1;
        n_den  = r_den;
        o_ready = (r_state == FS_IDLE);
        o_valid = (r_state == FS_PUSH);
        o_frac.num = r_p0;
        o_frac.den = r_den;
        unique case (r_state)
            FS_IDLE: begin
                n_item = i_item;
                if (i_item.a_den == '0) begin
                    n_item.a_num = '0;
                    n_item.a_den = DATA_W'(1);
                end
                if (i_item.b_den == '0) begin
                    n_item.b_num = '0;
                    n_item.b_den = DATA_W'(1);
                end
            end
            FS_MUL1: n_p0 = w_prod[DATA_W-1:0];
            FS_MUL2: n_p1 = w_prod[DATA_W-1:0];
            FS_SUM: begin
                if (r_item.operation == OP_ADD) n_p0 = r_p0 + r_p1;
                n_den = w_prod[DATA_W-1:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FS_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_item <= n_item;
        r_p0   <= n_p0;
        r_p1   <= n_p1;
        r_den  <= n_den;
    end
endmodule

### src/ramr_queue.sv
// Short FIFO between front and back parts, flip-flop storage.
// Depends on ramr_pkg.
module ramr_queue
    import ramr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_frac i_data,
    output logic  o_valid,
    input  logic  i_ready,
    output t_frac o_data
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    t_frac r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic w_push, w_pop;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wr <= (r_wr == AW'(DEPTH-1)) ? '0 : r_wr + 1'b1;
            if (w_pop)  r_rd <= (r_rd == AW'(DEPTH-1)) ? '0 : r_rd + 1'b1;
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
        if (w_push) r_mem[r_wr] <= i_data;
    end
endmodule

### src/ramr_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating (C) semantics.
// Depends on ramr_pkg.
module ramr_divider
    import ramr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_dividend,
    input  logic [DATA_W-1:0] i_divisor,
    output logic              o_done,
    output logic [DATA_W-1:0] o_quot,
    output logic [DATA_W-1:0] o_rem
);
    localparam int unsigned CW = $clog2(DATA_W + 1);
    logic [DATA_W-1:0] r_q, r_d;
    logic [DATA_W:0]   r_r;
    logic [CW-1:0]     r_cnt;
    logic              r_busy, r_done, r_qneg, r_rneg;
    logic [DATA_W:0]   w_sh, w_diff;
    logic [DATA_W-1:0] w_ua, w_ub;

    assign w_ua   = i_dividend[DATA_W-1] ? (~i_dividend + 1'b1) : i_dividend;
    assign w_ub   = i_divisor[DATA_W-1] ? (~i_divisor + 1'b1) : i_divisor;
    assign w_sh   = {r_r[DATA_W-1:0], r_q[DATA_W-1]};
    assign w_diff = w_sh - {1'b0, r_d};
    assign o_done = r_done;
    assign o_quot = r_qneg ? (~r_q + 1'b1) : r_q;
    assign o_rem  = r_rneg ? (~r_r[DATA_W-1:0] + 1'b1) : r_r[DATA_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DATA_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start) begin
            r_q    <= w_ua;
            r_d    <= w_ub;
            r_r    <= '0;
            r_qneg <= i_dividend[DATA_W-1] ^ i_divisor[DATA_W-1];
            r_rneg <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            if (!w_diff[DATA_W]) begin
                r_r <= w_diff;
                r_q <= {r_q[DATA_W-2:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[DATA_W-2:0], 1'b0};
            end
        end
    end
endmodule

### src/ramr_back.sv
// Back part: Euclidean GCD by repeated remainders, then reduction of numerator and denominator;
// a zero or overflowing divisor gives the error beat 0/1. Depends on ramr_pkg and ramr_divider.
module ramr_back
    import ramr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_frac     i_frac,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    localparam logic [DATA_W-1:0] MIN_VAL = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DATA_W-1:0] NEG_ONE = '1;

    t_back_state r_state, n_state;
    logic [DATA_W-1:0] r_num, r_den, r_x, r_y;
    logic r_err;
    t_out_item r_out;
    logic w_start, w_done;
    logic [DATA_W-1:0] w_dvd, w_dvs, w_quot, w_rem;
    logic w_bad;

    ramr_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_done     (w_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_bad = (r_y == '0) || (r_x == MIN_VAL && r_y == NEG_ONE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:      if (i_valid) n_state = ST_GCD_START;
            ST_GCD_START: n_state = w_bad ? ST_DONE : ST_GCD_DIV;
            ST_GCD_DIV:   if (w_done) n_state = (w_rem == '0) ? ST_RED_NUM : ST_GCD_START;
            ST_RED_NUM:   if (w_done) n_state = ST_RED_DEN;
            ST_RED_DEN:   if (w_done) n_state = ST_DONE;
            ST_DONE:      if (i_ready) n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready = (r_state == ST_IDLE);
        o_valid = (r_state == ST_DONE);
        o_item  = r_out;
        w_start = 1'b0;
        w_dvd   = r_x;
        w_dvs   = r_y;
        unique case (r_state)
            ST_GCD_START: w_start = !w_bad;
            ST_GCD_DIV: if (w_done && w_rem == '0) begin
                w_start = 1'b1;
                w_dvd   = r_num;
                w_dvs   = r_y;
            end
            ST_RED_NUM: if (w_done) begin
                w_start = 1'b1;
                w_dvd   = r_den;
                w_dvs   = r_x;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
        unique case (r_state)
            ST_IDLE: if (i_valid) begin
                r_num <= i_frac.num;
                r_den <= i_frac.den;
                r_x   <= i_frac.num;
                r_y   <= i_frac.den;
                r_err <= 1'b0;
            end
            ST_GCD_START: if (w_bad) begin
                r_out.res_num <= '0;
                r_out.res_den <= DATA_W'(1);
                r_out.error   <= 1'b1;
            end
            ST_GCD_DIV: if (w_done) begin
                r_x <= r_y;
                r_y <= w_rem;
            end
            ST_RED_NUM: if (w_done) r_out.res_num <= w_quot;
            ST_RED_DEN: if (w_done) begin
                r_out.res_den <= w_quot;
                r_out.error   <= r_err;
            end
            default: ;
        endcase
    end
endmodule

### src/ramr_checker.sv
// Port-level checker for the rational block, bound to the top level.
// Depends on ramr_pkg and the channel interfaces.
module ramr_checker
    import ramr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_item out_data
);
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.error |-> out_data.res_num == '0 && out_data.res_den == 1)
        else $error("error beat not 0/1");
    a_den_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> out_data.res_den != '0)
        else $error("zero denominator in result");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");
    a_in_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input accepted on consecutive cycles");
endmodule

bind rational_add_mul_reduce_top ramr_checker u_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (s_in.valid),
    .in_ready  (s_in.ready),
    .out_valid (m_out.valid),
    .out_ready (m_out.ready),
    .out_data  (m_out.data)
);

### sim/tb_rational_add_mul_reduce_top.sv
// Testbench for rational_add_mul_reduce_top: directed and random fraction pairs,
// predicted results checked beat by beat. Depends on ramr_pkg, ramr_if and the top level.
module tb_rational_add_mul_reduce_top;
    import ramr_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   n_fail;
    t_out_item frac_q[$];

    ramr_in_if  s_in();
    ramr_out_if m_out();

    rational_add_mul_reduce_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (s_in.sink),
        .m_out   (m_out.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #60000000;
        $display("== FAIL ==");
        $finish;
    end

    function automatic t_out_item reduce_frac(t_in_item it);
        t_out_item r;
        logic [31:0] an, ad, bn, bd, num, den;
        longint x, y, m, g;
        an = it.a_num; ad = it.a_den; bn = it.b_num; bd = it.b_den;
        if (ad == 0) begin
            an = 0; ad = 1;
        end
        if (bd == 0) begin
            bn = 0; bd = 1;
        end
        if (it.operation == OP_ADD) num = an * bd + bn * ad;
        else num = an * bn;
        den = ad * bd;
        r.res_num = 32'd0; r.res_den = 32'd1; r.error = 1'b1;
        x = longint'(signed'(num));
        y = longint'(signed'(den));
        forever begin
            if (y == 0) return r;
            if (x == -64'sd2147483648 && y == -1) return r;
            m = x % y;
            x = y;
            y = m;
            if (m == 0) break;
        end
        g = x;
        r.res_num = 32'(longint'(signed'(num)) / g);
        r.res_den = 32'(longint'(signed'(den)) / g);
        r.error = 1'b0;
        return r;
    endfunction

    task automatic send_frac(logic op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        t_in_item it;
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_in.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        it.operation = op; it.a_num = an; it.a_den = ad; it.b_num = bn; it.b_den = bd;
        s_in.data  <= it;
        s_in.valid <= 1'b1;
        do @(posedge i_clk); while (!s_in.ready);
        frac_q.push_back(reduce_frac(it));
    endtask

    initial begin
        int stall;
        m_out.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (stall > 0) begin
                m_out.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_out.ready <= 1'b1;
            do @(posedge i_clk); while (!m_out.valid);
            if (frac_q.size() == 0) begin
                $display("%0t unexpected beat: actual %h", $time, m_out.data);
                n_fail++;
            end else begin
                t_out_item e;
                e = frac_q.pop_front();
                if (e.res_num !== m_out.data.res_num)
                    $display("%0t res_num: expected %h actual %h", $time, e.res_num,
                             m_out.data.res_num);
                if (e.res_den !== m_out.data.res_den)
                    $display("%0t res_den: expected %h actual %h", $time, e.res_den,
                             m_out.data.res_den);
                if (e.error !== m_out.data.error)
                    $display("%0t error: expected %b actual %b", $time, e.error,
                             m_out.data.error);
                if (e !== m_out.data) n_fail++;
            end
        end
    end

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'd0;
            4: return 32'($signed($urandom_range(0, 40)) - 20);
            5: return $urandom_range(0, 65535) << $urandom_range(0, 16);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        send_frac(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_frac(OP_MUL, 32'd2, 32'd4, 32'd3, 32'd9);
        send_frac(OP_ADD, 32'd5, 32'd0, 32'd7, 32'd3);
        send_frac(OP_MUL, 32'd5, 32'd2, 32'd7, 32'd0);
        send_frac(OP_ADD, 32'd5, 32'd0, 32'd7, 32'd0);
        send_frac(OP_MUL, 32'd1, 32'h0001_0000, 32'd1, 32'h0001_0000);
        send_frac(OP_ADD, 32'd3, 32'h8000_0000, 32'd1, 32'd2);
        send_frac(OP_MUL, 32'h8000_0000, 32'hffff_ffff, 32'd1, 32'd1);
        send_frac(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'hffff_ffff);
        send_frac(OP_MUL, 32'h8000_0000, 32'd1, 32'd1, 32'd1);
        send_frac(OP_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_frac(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff);
        send_frac(OP_ADD, 32'd0, 32'd7, 32'd0, 32'hffff_fffd);
        send_frac(OP_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        send_frac(OP_ADD, 32'hffff_fffb, 32'd6, 32'd4, 32'hffff_fff7);
        send_frac(OP_MUL, 32'h7fff_ffff, 32'h8000_0000, 32'd2, 32'd1);
        send_frac(OP_ADD, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555, 32'haaaa_aaaa);
    endtask

    task automatic test_random();
        repeat (640) begin
            send_frac(1'($urandom), pick_val(), pick_val(), pick_val(), pick_val());
        end
    endtask

    initial begin
        int waited;
        n_fail = 0;
        i_rst_n = 1'b0;
        s_in.valid = 1'b0;
        s_in.data  = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random();
        s_in.valid <= 1'b0;
        waited = 0;
        while (frac_q.size() != 0 && waited < 200000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (n_fail == 0 && frac_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
